[rtl/spm_pkg.sv]
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants for the stream pattern masker.
// ----------------------------------------------------------------------------
package spm_pkg;

  // largest pattern the window can hold
  localparam int MAX_PATTERN = 16;
  // window fill counter, holds 0 to MAX_PATTERN
  localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
  // window entry index
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  // width used to compare the 5-bit length register against MAX_PATTERN
  localparam int LEN_CMP_W   = (FILL_W > 5) ? FILL_W : 5;

  // input queue between front and back
  localparam int FQ_DEPTH    = 4;
  localparam int FQ_PTR_W    = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W    = $clog2(FQ_DEPTH + 1);

  localparam logic [7:0] STAR_BYTE = 8'h2A;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LEN    = 2'd0,
    CFG_PAT_LO = 2'd1,
    CFG_PAT_HI = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       stream_done;
  } out_item_t;

  // head of the input queue as seen by the back end
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } fq_head_t;

  // effective configuration handed to the back end
  typedef struct packed {
    logic [FILL_W-1:0]                len;
    logic [MAX_PATTERN-1:0][7:0]      pat;
  } spm_cfg_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_LOAD,
    BK_RUN,
    BK_STAR
  } bk_state_t;

endpackage

[rtl/spm_front.sv]
// ----------------------------------------------------------------------------
// spm_front
// Input side: accepts items and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module spm_front
  import spm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  output fq_head_t head,
  input  logic     head_pop
);

  in_item_t              q_r [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                  do_push;
  logic                  do_pop;

  // handshake decode
  assign in_full = (cnt_r == FQ_CNT_W'(FQ_DEPTH));
  assign do_push = in_push && !in_full;
  assign do_pop  = head_pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

[rtl/spm_back.sv]
// ----------------------------------------------------------------------------
// spm_back
// Window, pattern compare and result sequencer with an output register.
// ----------------------------------------------------------------------------
module spm_back
  import spm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  spm_cfg_t  cfg,
  input  fq_head_t  head,
  output logic      head_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  bk_state_t          state_r, state_nxt;
  logic [7:0]         win_r [MAX_PATTERN];
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [FILL_W-1:0]  star_cnt_r, star_cnt_nxt;
  logic               eos_r, eos_nxt;
  logic               out_vld_r, out_vld_nxt;
  out_item_t          out_item_r;

  logic               surplus;
  logic               at_len;
  logic               flush;
  logic               need_emit;
  logic               emit_ok;
  logic               match;
  logic               emit;
  logic [7:0]         emit_byte;
  logic               emit_last;
  logic               do_load;
  logic               do_shift;
  logic               do_clear;

  // window state decode
  assign surplus   = (fill_r > cfg.len);
  assign at_len    = (fill_r == cfg.len);
  assign flush     = eos_r && (fill_r != '0);
  assign need_emit = surplus || at_len || flush;
  assign emit_ok   = !out_vld_r || out_pop;

  // window against pattern, entries past the length ignored
  always_comb begin
    match = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((k < int'(cfg.len)) && (win_r[k] != cfg.pat[k])) begin
        match = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_LOAD: begin
        if (head.valid) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!need_emit) begin
          state_nxt = BK_LOAD;
        end else if (emit_ok && !surplus) begin
          if (at_len && match) begin
            state_nxt = (cfg.len == FILL_W'(1)) ? BK_LOAD : BK_STAR;
          end else if (emit_last) begin
            state_nxt = BK_LOAD;
          end
        end
      end
      BK_STAR: begin
        if (emit_ok && (star_cnt_r == FILL_W'(1))) begin
          state_nxt = BK_LOAD;
        end
      end
      default: state_nxt = BK_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    head_pop     = 1'b0;
    do_load      = 1'b0;
    do_shift     = 1'b0;
    do_clear     = 1'b0;
    emit         = 1'b0;
    emit_byte    = win_r[0];
    emit_last    = 1'b0;
    star_cnt_nxt = star_cnt_r;
    unique case (state_r)
      BK_LOAD: begin
        head_pop = head.valid;
        do_load  = head.valid;
      end
      BK_RUN: begin
        if (surplus) begin
          // oldest byte beyond the pattern length goes out unchanged
          emit     = emit_ok;
          do_shift = emit_ok;
        end else if (at_len && match) begin
          emit         = emit_ok;
          emit_byte    = STAR_BYTE;
          emit_last    = (cfg.len == FILL_W'(1));
          do_clear     = emit_ok;
          star_cnt_nxt = emit_ok ? cfg.len - 1'b1 : star_cnt_r;
        end else if (at_len) begin
          emit      = emit_ok;
          emit_last = !eos_r || (fill_r == FILL_W'(1));
          do_shift  = emit_ok;
        end else if (flush) begin
          emit      = emit_ok;
          emit_last = (fill_r == FILL_W'(1));
          do_shift  = emit_ok;
        end
      end
      BK_STAR: begin
        emit         = emit_ok;
        emit_byte    = STAR_BYTE;
        emit_last    = (star_cnt_r == FILL_W'(1));
        star_cnt_nxt = emit_ok ? star_cnt_r - 1'b1 : star_cnt_r;
      end
      default: begin
        head_pop = 1'b0;
      end
    endcase
  end

  // fill, end flag and output valid
  always_comb begin
    fill_nxt = fill_r;
    eos_nxt  = eos_r;
    if (do_load) begin
      fill_nxt = fill_r + 1'b1;
      eos_nxt  = head.item.end_of_stream;
    end else if (do_clear) begin
      fill_nxt = '0;
    end else if (do_shift) begin
      fill_nxt = fill_r - 1'b1;
    end
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_LOAD;
      fill_r     <= '0;
      star_cnt_r <= '0;
      eos_r      <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      star_cnt_r <= star_cnt_nxt;
      eos_r      <= eos_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // window bytes, oldest in entry 0
  always_ff @(posedge clk) begin
    if (do_load) begin
      win_r[fill_r[IDX_W-1:0]] <= head.item.in_byte;
    end else if (do_shift) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r.out_byte    <= emit_byte;
      out_item_r.run_end     <= emit_last;
      out_item_r.stream_done <= emit_last && eos_r;
    end
  end

  assign out_empty = !out_vld_r;
  assign out_item  = out_item_r;

endmodule

[rtl/stream_pattern_masker_core.sv]
// ----------------------------------------------------------------------------
// stream_pattern_masker_core
// Byte stream pass-through that masks each pattern occurrence with '*' bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_byte, end_of_stream) enter through in_push / in_full
//   into a 4-entry queue. Results (out_byte, run_end, stream_done) leave
//   through out_empty / out_pop; the oldest result sits on out_item while
//   out_empty is low. The config port (cfg_valid / cfg_ready, always ready)
//   writes pattern_length, pattern bytes 0-7 and pattern bytes 8-15; write
//   only while the block is idle.
//   Timing: the back-end sequencer loads an item into the window, then
//   produces its results, one result per cycle while the output register
//   can take them, or goes straight back to loading if the item has no
//   result. A result appears on the output in the cycle after it is
//   produced. The single output register sets the pace of the sequencer
//   under a stalled receiver: while a result waits, no further result is
//   produced, but the input queue keeps taking items until it fills.
//   Reset clears the queue, the window fill and the output; pattern length
//   returns to 1 and the pattern bytes to 0.
// ----------------------------------------------------------------------------
module stream_pattern_masker_core
  import spm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_item,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [4:0]           len_r;
  logic [63:0]          pat_lo_r;
  logic [63:0]          pat_hi_r;
  logic [LEN_CMP_W-1:0] len_ext;
  spm_cfg_t             cfg;
  fq_head_t             head;
  logic                 head_pop;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= 5'd1;
      pat_lo_r <= '0;
      pat_hi_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEN:    len_r    <= cfg_data[4:0];
        CFG_PAT_LO: pat_lo_r <= cfg_data;
        CFG_PAT_HI: pat_hi_r <= cfg_data;
        default:    len_r    <= len_r;
      endcase
    end
  end

  // effective length clamped to 1..MAX_PATTERN, pattern bytes zero beyond byte 15
  assign len_ext = LEN_CMP_W'(len_r);
  always_comb begin
    if (len_ext == '0) begin
      cfg.len = FILL_W'(1);
    end else if (len_ext > LEN_CMP_W'(MAX_PATTERN)) begin
      cfg.len = FILL_W'(MAX_PATTERN);
    end else begin
      cfg.len = FILL_W'(len_ext);
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (k < 8) begin
        cfg.pat[k] = pat_lo_r[8*k +: 8];
      end else if (k < 16) begin
        cfg.pat[k] = pat_hi_r[8*(k-8) +: 8];
      end else begin
        cfg.pat[k] = 8'h00;
      end
    end
  end

  spm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .head     (head),
    .head_pop (head_pop)
  );

  spm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head      (head),
    .head_pop  (head_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

[dv/spm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_checker
// Watches the item, result and config channels of stream_pattern_masker_core,
// keeps its own copy of the pattern window, predicts every masked byte and
// compares each popped result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module spm_checker
  import spm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  in_item_t    in_item,
  input  logic        out_empty,
  input  logic        out_pop,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          stars_seen
);

  // shadow registers
  logic [4:0]  len_reg = 5'd1;
  logic [63:0] pat_lo  = '0;
  logic [63:0] pat_hi  = '0;

  // shadow window, oldest byte at index 0
  logic [7:0]  win [MAX_PATTERN];
  int          win_fill = 0;

  // predicted output bytes, oldest first
  out_item_t   masked_q[$];

  int          errs      = 0;
  int          n_results = 0;
  int          n_stars   = 0;

  // length in use: zero acts as one, anything above the window acts as full
  function automatic int active_len();
    int l;
    l = int'(len_reg);
    if (l == 0) l = 1;
    if (l > MAX_PATTERN) l = MAX_PATTERN;
    return l;
  endfunction

  function automatic logic [7:0] pat_byte(int k);
    if (k < 8) return pat_lo[8*k +: 8];
    if (k < 16) return pat_hi[8*(k-8) +: 8];
    return 8'h00;
  endfunction

  // drop the oldest window byte
  task automatic shift_window();
    int k;
    for (k = 0; k + 1 < win_fill; k++) win[k] = win[k + 1];
    win_fill--;
  endtask

  // run one input item through the window and queue the bytes it releases
  task automatic predict_masked(input in_item_t it);
    logic [7:0] bytes[$];
    out_item_t  r;
    int         len;
    int         k;
    bit         hit;
    len = active_len();
    win[win_fill] = it.in_byte;
    win_fill++;
    // surplus left over from a longer pattern leaves unchanged
    while (win_fill > len) begin
      bytes.push_back(win[0]);
      shift_window();
    end
    // full window: stars on a hit, else release the oldest byte
    if (win_fill == len) begin
      hit = 1'b1;
      for (k = 0; k < len; k++)
        if (win[k] != pat_byte(k)) hit = 1'b0;
      if (hit) begin
        for (k = 0; k < len; k++) bytes.push_back(STAR_BYTE);
        win_fill = 0;
      end else begin
        bytes.push_back(win[0]);
        shift_window();
      end
    end
    // end of stream flushes what is held as is
    if (it.end_of_stream) begin
      for (k = 0; k < win_fill; k++) bytes.push_back(win[k]);
      win_fill = 0;
    end
    for (k = 0; k < bytes.size(); k++) begin
      r.out_byte    = bytes[k];
      r.run_end     = (k == bytes.size() - 1);
      r.stream_done = it.end_of_stream && (k == bytes.size() - 1);
      masked_q.push_back(r);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    n_results++;
    if (got.out_byte == STAR_BYTE) n_stars++;
    if (masked_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual byte %h run_end %b done %b",
               $time, got.out_byte, got.run_end, got.stream_done);
      errs++;
    end else begin
      want = masked_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
        errs++;
      end
      if (got.run_end !== want.run_end) begin
        $display("%0t: run_end expected %b actual %b", $time, want.run_end, got.run_end);
        errs++;
      end
      if (got.stream_done !== want.stream_done) begin
        $display("%0t: stream_done expected %b actual %b", $time, want.stream_done,
                 got.stream_done);
        errs++;
      end
    end
  endtask

  // sample all three channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      len_reg  = 5'd1;
      pat_lo   = '0;
      pat_hi   = '0;
      win_fill = 0;
      masked_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LEN:    len_reg = cfg_data[4:0];
          CFG_PAT_LO: pat_lo  = cfg_data;
          CFG_PAT_HI: pat_hi  = cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full) predict_masked(in_item);
      if (out_pop && !out_empty) check_result(out_item);
    end
    fail_count   <= errs;
    pending      <= masked_q.size();
    results_seen <= n_results;
    stars_seen   <= n_stars;
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives stream_pattern_masker_core with directed pattern cases and random
// phases of byte streams built around the configured pattern, with random
// stalls on both sides; spm_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import spm_pkg::*;

  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEM_TARGET    = 250;
  localparam int CALM_AFTER     = 200;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_push   = 1'b0;
  logic        in_full;
  in_item_t    in_item   = '0;
  logic        out_empty;
  logic        out_pop   = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_LEN;
  logic [63:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int results_seen;
  int stars_seen;

  int items_sent   = 0;
  int phases       = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;
  bit calm         = 1'b0;
  bit sender_idles = 1'b1;

  stream_pattern_masker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spm_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_item      (in_item),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_item     (out_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .stars_seen   (stars_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: random stall bursts, none in the closing part
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_pop    <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_n && !calm && $urandom_range(0, 11) == 0) begin
      out_pop    <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_pop <= 1'b1;
    end
  end

  // watchdog on cycles in which nothing moves
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("stream_pattern_masker_core test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [7:0] pick_byte(bit narrow);
    if (narrow) return 8'h41 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // write all three registers back to back
  task automatic write_pattern(input logic [63:0] len_data, input logic [63:0] lo,
                               input logic [63:0] hi);
    cfg_index <= CFG_LEN;
    cfg_data  <= len_data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_PAT_LO;
    cfg_data  <= lo;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_PAT_HI;
    cfg_data  <= hi;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one item, with an occasional idle burst in front of it
  task automatic send_item(input logic [7:0] b, input logic eos);
    in_item_t it;
    if (sender_idles && !calm && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    it.in_byte       = b;
    it.end_of_stream = eos;
    in_item <= it;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  // hold the sender until every predicted byte is out and the core has settled
  task automatic wait_stream_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [7:0]  pat [16];
    logic [7:0]  stream_q[$];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_data;
    int          len_code;
    int          eff;
    int          target;
    int          cut;
    int          k;
    bit          narrow;
    bit          ends_stream;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: one-byte pattern of zero
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    wait_stream_idle();

    // three-byte pattern: partial hit, shifted hit, short flush at the end
    write_pattern(64'd3, 64'h63_62_61, 64'd0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h63, 1'b0);
    send_item(8'h7A, 1'b1);

    // two bytes left in the window, then the length shrinks to zero under them
    send_item(8'h78, 1'b0);
    send_item(8'h79, 1'b0);
    wait_stream_idle();
    write_pattern(64'd0, 64'h61, 64'd0);
    send_item(8'h61, 1'b1);
    wait_stream_idle();

    // length 31 clamps to the full window: sixteen stars in one run
    write_pattern('1, '1, '0);
    for (k = 0; k < 16; k++) send_item((k < 8) ? 8'hFF : 8'h00, k == 15);
    wait_stream_idle();

    // random phases of streams built around the pattern
    while (items_sent < ITEM_TARGET) begin
      phases++;
      if (items_sent >= CALM_AFTER) calm <= 1'b1;
      sender_idles = ($urandom_range(0, 3) != 0);
      case (phases)
        1:       len_code = 0;
        2:       len_code = 31;
        3:       len_code = 16;
        4:       len_code = 17;
        default: len_code = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(1, 6);
      endcase
      eff = (len_code == 0) ? 1 : (len_code > MAX_PATTERN) ? MAX_PATTERN : len_code;
      narrow = ($urandom_range(0, 3) != 0);
      for (k = 0; k < 16; k++) begin
        pat[k] = pick_byte(narrow);
        if (k < 8) lo[8*k +: 8] = pat[k];
        else hi[8*(k-8) +: 8] = pat[k];
      end
      len_data      = {$urandom(), $urandom()};
      len_data[4:0] = 5'(len_code);
      write_pattern(len_data, lo, hi);

      // mostly whole patterns, some cut short, some noise
      target = $urandom_range(12, 40);
      stream_q.delete();
      while (stream_q.size() < target) begin
        case ($urandom_range(0, 7))
          0, 1, 2: begin
            for (k = 0; k < eff; k++) stream_q.push_back(pat[k]);
          end
          3, 4: begin
            cut = $urandom_range(0, eff - 1);
            for (k = 0; k < cut; k++) stream_q.push_back(pat[k]);
            stream_q.push_back(pick_byte(narrow));
          end
          default: begin
            repeat ($urandom_range(1, 4)) stream_q.push_back(pick_byte(narrow));
          end
        endcase
      end

      // some phases leave bytes in the window for the next length change
      ends_stream = ($urandom_range(0, 3) != 0);
      for (k = 0; k < stream_q.size(); k++)
        send_item(stream_q[k], (k == stream_q.size() - 1) ? ends_stream
                                                          : ($urandom_range(0, 23) == 0));
      wait_stream_idle();
    end

    $display("sent %0d items: directed pattern cases, then %0d random phases", items_sent,
             phases);
    $display("compared %0d result bytes, %0d of them star bytes", results_seen, stars_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("stream_pattern_masker_core test passed");
    end else begin
      $display("stream_pattern_masker_core test failed");
    end
    $finish;
  end

endmodule
